### rtl/pattern_buzzer_sequencer_macros.svh
// assertion macros for the pattern buzzer sequencer
// no dependencies; included by the files that assert
`ifndef PATTERN_BUZZER_SEQUENCER_MACROS_SVH
`define PATTERN_BUZZER_SEQUENCER_MACROS_SVH

// same-cycle implication, disabled in reset
`define PBS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define PBS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/pbs_pkg.sv
// shared types and constants of the pattern buzzer sequencer
// no dependencies; used by the top, pbs_front and pbs_player
package pbs_pkg;

   // fixed field widths
   localparam int unsigned PID_W    = 5;
   localparam int unsigned POS_W    = 5;
   localparam int unsigned DUR_W    = 8;
   localparam int unsigned IRQ_W    = 8;
   localparam int unsigned UNIT_W   = 8;
   localparam int unsigned TICK_W   = 16;
   localparam int unsigned QUEUED_W = 4;

   // unit register after reset
   localparam logic [UNIT_W-1:0] UNIT_RESET = 8'd8;

   // item kinds after classification
   typedef enum logic [1:0] {
      OP_TICK = 2'd0,
      OP_PLAY = 2'd1,
      OP_LOAD = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   // classified word from front to player
   typedef struct packed {
      op_type             kind;
      logic [PID_W-1:0]   pattern_id;
      logic [POS_W-1:0]   position;
      logic [DUR_W-1:0]   duration;
      logic [IRQ_W-1:0]   interrupt_index;
   } cmd_type;

   // result word
   typedef struct packed {
      logic                line_level;
      logic                playing;
      logic [QUEUED_W-1:0] queued;
      logic                dropped;
   } rsp_type;

endpackage

### rtl/pattern_buzzer_sequencer.sv
// channel   dir  handshake              words
// req_      in   req_push / req_full    operation, pattern_id, position, duration, intr index
// rsp_      out  rsp_pop / rsp_empty    line_level, playing, queued, dropped
// csr_      in   csr_valid / csr_ready  unit_ticks (one register)
//
// in the player a word passes idle, eval and done; an element that starts timing adds a read,
// an end mark a read and an eval, a start from idle a pop and an eval, a preemption all three;
// the longest word is a pattern ending with QUEUE_DEPTH empty patterns waiting.
// after reset the pattern store is wiped one entry a cycle, all NUM_PATTERNS*MAX_STEPS entries
// (1024 by default), with req_full high; csr writes are taken throughout.
// a two-word command queue and a two-word result queue let each side stall on its own.
// depends on pbs_pkg, pbs_front, pbs_player, pbs_queue, pbs_ram and the macros header
`include "pattern_buzzer_sequencer_macros.svh"

module pattern_buzzer_sequencer #(
   parameter int unsigned QUEUE_DEPTH  = 8,
   parameter int unsigned NUM_PATTERNS = 32,
   parameter int unsigned MAX_STEPS    = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  logic [1:0]                      req_operation,
   input  logic [pbs_pkg::PID_W-1:0]       req_pattern_id,
   input  logic [pbs_pkg::POS_W-1:0]       req_position,
   input  logic [pbs_pkg::DUR_W-1:0]       req_duration,
   input  logic [pbs_pkg::IRQ_W-1:0]       req_interrupt_index,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic                            rsp_line_level,
   output logic                            rsp_playing,
   output logic [pbs_pkg::QUEUED_W-1:0]    rsp_queued,
   output logic                            rsp_dropped,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [pbs_pkg::UNIT_W-1:0]      csr_unit_ticks
);

   logic [pbs_pkg::UNIT_W-1:0] unit_ff;
   logic                       clearing;
   logic                       cmd_valid;
   logic                       cmd_pop;
   pbs_pkg::cmd_type           cmd;
   logic                       rsp_full;
   logic                       rsp_push;
   pbs_pkg::rsp_type           rsp_in;
   pbs_pkg::rsp_type           rsp_out;

   // unit register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ff <= pbs_pkg::UNIT_RESET;
      end else if (csr_valid && csr_ready) begin
         unit_ff <= csr_unit_ticks;
      end
   end

   // front end
   pbs_front #(
      .NUM_PATTERNS (NUM_PATTERNS),
      .MAX_STEPS    (MAX_STEPS)
   ) u_front (
      .clock               (clock),
      .reset               (reset),
      .hold                (clearing),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_operation       (req_operation),
      .req_pattern_id      (req_pattern_id),
      .req_position        (req_position),
      .req_duration        (req_duration),
      .req_interrupt_index (req_interrupt_index),
      .cmd_valid           (cmd_valid),
      .cmd                 (cmd),
      .cmd_pop             (cmd_pop)
   );

   // player
   pbs_player #(
      .QUEUE_DEPTH  (QUEUE_DEPTH),
      .NUM_PATTERNS (NUM_PATTERNS),
      .MAX_STEPS    (MAX_STEPS)
   ) u_player (
      .clock      (clock),
      .reset      (reset),
      .unit_ticks (unit_ff),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop),
      .rsp_full   (rsp_full),
      .rsp_push   (rsp_push),
      .rsp        (rsp_in),
      .clearing   (clearing)
   );

   // result queue
   pbs_queue #(
      .WIDTH($bits(pbs_pkg::rsp_type))
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (rsp_push),
      .wr_data (rsp_in),
      .full    (rsp_full),
      .pop     (rsp_pop),
      .rd_data (rsp_out),
      .empty   (rsp_empty)
   );

   assign rsp_line_level = rsp_out.line_level;
   assign rsp_playing    = rsp_out.playing;
   assign rsp_queued     = rsp_out.queued;
   assign rsp_dropped    = rsp_out.dropped;

   // checks
   `PBS_ASSERT_IMPLY(a_wipe_blocks_input, clock, reset, clearing, req_full, "word accepted during store wipe")
   `PBS_ASSERT_IMPLY(a_wipe_no_result, clock, reset, clearing, rsp_empty, "result present during store wipe")
   `PBS_ASSERT_NEXT(a_wipe_once, clock, reset, !clearing, !clearing, "store wipe restarted without reset")
   `PBS_ASSERT_IMPLY(a_level_needs_play, clock, reset, !rsp_empty && rsp_line_level, rsp_playing, "line high while not playing")
   `PBS_ASSERT_IMPLY(a_idle_queue_empty, clock, reset, !rsp_empty && !rsp_playing, rsp_queued == 4'd0, "idle with patterns waiting")

endmodule

### rtl/pbs_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module pbs_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 32
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/pbs_queue.sv
// two-entry register queue with push/full and pop/empty
// no dependencies
module pbs_queue #(
   parameter int unsigned WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   logic [WIDTH-1:0] data_ff [2];
   logic [1:0]       cnt_ff;
   logic             wr_ptr_ff;
   logic             rd_ptr_ff;
   logic             do_push;
   logic             do_pop;

   assign full    = (cnt_ff == 2'd2);
   assign empty   = (cnt_ff == 2'd0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign rd_data = data_ff[rd_ptr_ff];

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ptr_ff] <= wr_data;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (do_push && !do_pop) begin
            cnt_ff <= cnt_ff + 2'd1;
         end else if (do_pop && !do_push) begin
            cnt_ff <= cnt_ff - 2'd1;
         end
      end
   end

endmodule

### rtl/pbs_front.sv
// front end: accepts input words, classifies them and queues them for the player
// depends on pbs_pkg and pbs_queue
module pbs_front #(
   parameter int unsigned NUM_PATTERNS = 32,
   parameter int unsigned MAX_STEPS    = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         hold,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic [1:0]                   req_operation,
   input  logic [pbs_pkg::PID_W-1:0]    req_pattern_id,
   input  logic [pbs_pkg::POS_W-1:0]    req_position,
   input  logic [pbs_pkg::DUR_W-1:0]    req_duration,
   input  logic [pbs_pkg::IRQ_W-1:0]    req_interrupt_index,
   output logic                         cmd_valid,
   output pbs_pkg::cmd_type             cmd,
   input  logic                         cmd_pop
);

   pbs_pkg::cmd_type cmd_in;
   logic             load_ok;
   logic             q_full;
   logic             q_empty;

   // loads outside the store are dropped here
   assign load_ok = (32'(req_pattern_id) < NUM_PATTERNS) && (32'(req_position) < MAX_STEPS);

   // classify the incoming word
   always_comb begin
      cmd_in.pattern_id      = req_pattern_id;
      cmd_in.position        = req_position;
      cmd_in.duration        = req_duration;
      cmd_in.interrupt_index = req_interrupt_index;
      unique case (req_operation)
         pbs_pkg::OP_TICK: cmd_in.kind = pbs_pkg::OP_TICK;
         pbs_pkg::OP_PLAY: cmd_in.kind = pbs_pkg::OP_PLAY;
         pbs_pkg::OP_LOAD: cmd_in.kind = load_ok ? pbs_pkg::OP_LOAD : pbs_pkg::OP_NONE;
         default:          cmd_in.kind = pbs_pkg::OP_NONE;
      endcase
   end

   // command queue between front and player
   pbs_queue #(
      .WIDTH($bits(pbs_pkg::cmd_type))
   ) u_cmd_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (req_push & ~req_full),
      .wr_data (cmd_in),
      .full    (q_full),
      .pop     (cmd_pop),
      .rd_data (cmd),
      .empty   (q_empty)
   );

   assign req_full  = q_full | hold;
   assign cmd_valid = ~q_empty;

endmodule

### rtl/pbs_player.sv
// back end: executes words, keeps the play queue and the pattern store, runs the player
// depends on pbs_pkg and pbs_ram
module pbs_player #(
   parameter int unsigned QUEUE_DEPTH  = 8,
   parameter int unsigned NUM_PATTERNS = 32,
   parameter int unsigned MAX_STEPS    = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [pbs_pkg::UNIT_W-1:0]    unit_ticks,
   input  logic                          cmd_valid,
   input  pbs_pkg::cmd_type              cmd,
   output logic                          cmd_pop,
   input  logic                          rsp_full,
   output logic                          rsp_push,
   output pbs_pkg::rsp_type              rsp,
   output logic                          clearing
);

   localparam int unsigned SDEPTH = NUM_PATTERNS * MAX_STEPS;
   localparam int unsigned SAW    = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
   localparam int unsigned QAW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CW     = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned SIW    = $clog2(MAX_STEPS + 1);
   localparam int unsigned QEW    = pbs_pkg::PID_W + pbs_pkg::IRQ_W;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_EVAL = 5'b00010,
      ST_POP  = 5'b00100,
      ST_READ = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   state_type                     state_ff;
   logic [QAW-1:0]                head_ff;
   logic [CW-1:0]                 count_ff;
   logic                          active_ff;
   logic [pbs_pkg::PID_W-1:0]     cur_pat_ff;
   logic [pbs_pkg::IRQ_W-1:0]     cur_irq_ff;
   logic [SIW-1:0]                step_ff;
   logic                          next_lvl_ff;
   logic                          drive_ff;
   logic [pbs_pkg::TICK_W-1:0]    ticks_ff;
   logic                          dropped_ff;
   logic                          clear_ff;
   logic [SAW-1:0]                clear_addr_ff;

   logic                          start;
   logic                          q_full;
   logic [QAW:0]                  tail_sum;
   logic [QAW-1:0]                tail;
   logic [QAW-1:0]                head_in;
   logic [31:0]                   rd_addr_full;
   logic [31:0]                   wr_addr_full;
   logic                          elem_oob;
   logic [pbs_pkg::DUR_W-1:0]     elem;
   logic [pbs_pkg::UNIT_W-1:0]    units;
   logic [pbs_pkg::TICK_W-1:0]    ticks_in;
   logic                          preempt;
   logic                          store_we;
   logic [SAW-1:0]                store_waddr;
   logic [pbs_pkg::DUR_W-1:0]     store_wdata;
   logic [pbs_pkg::DUR_W-1:0]     store_rdata;
   logic                          fifo_we;
   logic [QEW-1:0]                fifo_rdata;

   // word taken from the command queue
   assign start   = (state_ff == ST_IDLE) && cmd_valid && !clear_ff;
   assign cmd_pop = start;
   assign q_full  = (32'(count_ff) >= QUEUE_DEPTH);

   // play queue pointers
   assign tail_sum = {1'b0, head_ff} + (QAW + 1)'(count_ff);
   assign tail     = (tail_sum >= (QAW + 1)'(QUEUE_DEPTH)) ?
                     QAW'(tail_sum - (QAW + 1)'(QUEUE_DEPTH)) : QAW'(tail_sum);
   assign head_in  = (32'(head_ff) + 32'd1 >= QUEUE_DEPTH) ? '0 : head_ff + QAW'(1);

   // pattern store addressing
   assign rd_addr_full = 32'(cur_pat_ff) * 32'(MAX_STEPS) + 32'(step_ff);
   assign wr_addr_full = 32'(cmd.pattern_id) * 32'(MAX_STEPS) + 32'(cmd.position);
   assign elem_oob     = (32'(cur_pat_ff) >= NUM_PATTERNS) || (32'(step_ff) >= MAX_STEPS);
   assign elem         = elem_oob ? '0 : store_rdata;

   // element timing and preemption
   assign units    = (unit_ticks == '0) ? pbs_pkg::UNIT_W'(1) : unit_ticks;
   assign ticks_in = pbs_pkg::TICK_W'(elem) * pbs_pkg::TICK_W'(units);
   assign preempt  = (32'(step_ff) >= 32'(cur_irq_ff)) && (count_ff != '0);

   // store write: wipe pass first, then loads
   assign store_we    = clear_ff || (start && (cmd.kind == pbs_pkg::OP_LOAD));
   assign store_waddr = clear_ff ? clear_addr_ff : wr_addr_full[SAW-1:0];
   assign store_wdata = clear_ff ? '0 : cmd.duration;

   assign fifo_we = start && (cmd.kind == pbs_pkg::OP_PLAY) && !q_full;

   pbs_ram #(
      .WIDTH(pbs_pkg::DUR_W),
      .DEPTH(SDEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_we),
      .wr_addr (store_waddr),
      .wr_data (store_wdata),
      .rd_addr (rd_addr_full[SAW-1:0]),
      .rd_data (store_rdata)
   );

   pbs_ram #(
      .WIDTH(QEW),
      .DEPTH(QUEUE_DEPTH)
   ) u_play_fifo (
      .clock   (clock),
      .wr_en   (fifo_we),
      .wr_addr (tail),
      .wr_data ({cmd.pattern_id, cmd.interrupt_index}),
      .rd_addr (head_ff),
      .rd_data (fifo_rdata)
   );

   // store wipe after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff      <= 1'b1;
         clear_addr_ff <= '0;
      end else if (clear_ff) begin
         clear_addr_ff <= clear_addr_ff + SAW'(1);
         if (clear_addr_ff == SAW'(SDEPTH - 1)) begin
            clear_ff <= 1'b0;
         end
      end
   end

   // player sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         head_ff     <= '0;
         count_ff    <= '0;
         active_ff   <= 1'b0;
         cur_pat_ff  <= '0;
         cur_irq_ff  <= '0;
         step_ff     <= '0;
         next_lvl_ff <= 1'b0;
         drive_ff    <= 1'b0;
         ticks_ff    <= '0;
         dropped_ff  <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  dropped_ff <= 1'b0;
                  unique case (cmd.kind)
                     pbs_pkg::OP_TICK: begin
                        if (ticks_ff != '0) begin
                           ticks_ff <= ticks_ff - pbs_pkg::TICK_W'(1);
                        end
                     end
                     pbs_pkg::OP_PLAY: begin
                        if (q_full) begin
                           dropped_ff <= 1'b1;
                        end else begin
                           count_ff <= count_ff + CW'(1);
                        end
                     end
                     default: begin
                     end
                  endcase
                  state_ff <= ST_EVAL;
               end
            end
            ST_EVAL: begin
               if (ticks_ff != '0) begin
                  state_ff <= ST_DONE;
               end else if (!active_ff) begin
                  state_ff <= (count_ff == '0) ? ST_DONE : ST_POP;
               end else begin
                  state_ff <= ST_READ;
               end
            end
            ST_POP: begin
               // start the pattern at the queue head
               cur_pat_ff  <= fifo_rdata[QEW-1:pbs_pkg::IRQ_W];
               cur_irq_ff  <= fifo_rdata[pbs_pkg::IRQ_W-1:0];
               head_ff     <= head_in;
               count_ff    <= count_ff - CW'(1);
               active_ff   <= 1'b1;
               step_ff     <= '0;
               next_lvl_ff <= 1'b0;
               state_ff    <= ST_EVAL;
            end
            ST_READ: begin
               if (elem == '0) begin
                  // end mark
                  drive_ff  <= 1'b0;
                  active_ff <= 1'b0;
                  state_ff  <= ST_EVAL;
               end else if (preempt) begin
                  state_ff <= ST_POP;
               end else begin
                  drive_ff    <= next_lvl_ff;
                  next_lvl_ff <= ~next_lvl_ff;
                  step_ff     <= step_ff + SIW'(1);
                  ticks_ff    <= ticks_in;
                  state_ff    <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (!rsp_full) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // result word
   assign rsp_push       = (state_ff == ST_DONE) && !rsp_full;
   assign rsp.line_level = drive_ff;
   assign rsp.playing    = active_ff;
   assign rsp.queued     = pbs_pkg::QUEUED_W'(count_ff);
   assign rsp.dropped    = dropped_ff;
   assign clearing       = clear_ff;

endmodule
